// ===== hdl/cik_pkg.sv =====
// Shared types, constants and the angle table for the chassis kinematics block.
package cik_pkg;

	localparam int VW = 48;
	localparam int QDEPTH = 4;

	localparam logic [1:0] MODE_OMNI4   = 2'd0;
	localparam logic [1:0] MODE_SWERVE4 = 2'd1;
	localparam logic [1:0] MODE_OMNI3   = 2'd2;
	localparam logic [1:0] MODE_SWERVE3 = 2'd3;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	// 1/sqrt2 and sqrt3/2 in Q16
	localparam logic [16:0] K_INV_SQRT2 = 17'd46341;
	localparam logic [16:0] K_SIN60     = 17'd56756;

	localparam int CORDIC_MAX = 24;

	typedef struct packed {
		logic [1:0]            idx;
		logic signed [VW-1:0]  x;
		logic signed [VW-1:0]  y;
		logic                  last;
		logic                  swerve;
	} job_t;

	// atan(2^-i) in degrees * 25600
	function automatic logic [20:0] cik_atan(input logic [4:0] i);
		logic [20:0] r;
		case (i)
			5'd0:  r = 21'd1152000;
			5'd1:  r = 21'd680065;
			5'd2:  r = 21'd359328;
			5'd3:  r = 21'd182400;
			5'd4:  r = 21'd91554;
			5'd5:  r = 21'd45822;
			5'd6:  r = 21'd22916;
			5'd7:  r = 21'd11459;
			5'd8:  r = 21'd5730;
			5'd9:  r = 21'd2865;
			5'd10: r = 21'd1432;
			5'd11: r = 21'd716;
			5'd12: r = 21'd358;
			5'd13: r = 21'd179;
			5'd14: r = 21'd90;
			5'd15: r = 21'd45;
			5'd16: r = 21'd22;
			5'd17: r = 21'd11;
			5'd18: r = 21'd6;
			5'd19: r = 21'd3;
			5'd20: r = 21'd1;
			5'd21: r = 21'd1;
			default: r = 21'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/cik_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module cik_isqrt #(
	parameter int IN_W = 48
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IN_W-1:0] operand,
	output logic            busy,
	output logic            done,
	output logic [IN_W/2-1:0] root
);

	localparam int OUT_W = IN_W / 2;
	localparam int CW = $clog2(OUT_W + 1);

	logic [IN_W-1:0]  rad_q;
	logic [OUT_W+1:0] rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [OUT_W+1:0] rem_sh;
	logic [OUT_W+1:0] trial;
	logic             ge;

	assign rem_sh = {rem_q[OUT_W-1:0], rad_q[IN_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[OUT_W-2:0], ge};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CW'(OUT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/cik_queue.sv =====
// Short queue of wheel jobs between the front and back halves.
module cik_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cik_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output cik_pkg::job_t pop_data,
	output logic          empty
);

	localparam int AW = $clog2(cik_pkg::QDEPTH);

	cik_pkg::job_t   mem_q [cik_pkg::QDEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     cnt_q;

	assign full     = cnt_q == (AW+1)'(cik_pkg::QDEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

endmodule

// ===== hdl/cik_front.sv =====
// Front half: takes a velocity word, applies the planar limit, emits wheel vectors.
module cik_front #(
	parameter int MAX_WHEELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  vel_x,
	input  logic signed [15:0]  vel_y,
	input  logic signed [15:0]  vel_rot,
	input  logic [1:0]          mode,
	input  logic [10:0]         radius,
	input  logic [14:0]         limit,
	output logic                push,
	output cik_pkg::job_t       push_data,
	input  logic                full
);

	localparam int VW = cik_pkg::VW;

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_MUL   = 7'b0000010,
		F_CMP   = 7'b0000100,
		F_SQRT  = 7'b0001000,
		F_DIV   = 7'b0010000,
		F_SCALE = 7'b0100000,
		F_EMIT  = 7'b1000000
	} fstate_t;

	fstate_t state_q;

	logic signed [15:0] vx_q, vy_q, vr_q;
	logic [30:0]        sqx_q, sqy_q;
	logic [29:0]        lim2_q, ax_q, ay_q;
	logic signed [27:0] vrr_q;
	logic [23:0]        m8_q;
	logic [24:0]        rx_q, ry_q;
	logic [33:0]        nx_q, ny_q;
	logic [33:0]        qx_q, qy_q;
	logic [5:0]         dcnt_q;
	logic signed [34:0] px_q, py_q;
	logic signed [52:0] kxp_q, kyp_q;
	logic signed [45:0] tp_q;
	logic [1:0]         k_q;

	logic [15:0]        absx, absy;
	logic [31:0]        ssum;
	logic               sq_start, sq_done, sq_busy;
	logic [23:0]        sq_root;
	logic [25:0]        tx, ty;
	logic               gex, gey;
	logic [16:0]        kxy, krot;
	logic [2:0]         nwheel;
	logic               last_k;

	logic signed [VW-1:0] px, py, rot, kx, ky, tt, hy, rh, jx, jy;

	assign absx = vx_q[15] ? 16'(-vx_q) : 16'(vx_q);
	assign absy = vy_q[15] ? 16'(-vy_q) : 16'(vy_q);
	assign ssum = {1'b0, sqx_q} + {1'b0, sqy_q};

	assign sq_start = (state_q == F_CMP) && (ssum > {2'b00, lim2_q});

	cik_isqrt #(.IN_W(48)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand ({ssum, 16'h0000}),
		.busy    (sq_busy),
		.done    (sq_done),
		.root    (sq_root)
	);

	assign tx  = {rx_q, nx_q[33]};
	assign ty  = {ry_q, ny_q[33]};
	assign gex = tx >= {2'b00, m8_q};
	assign gey = ty >= {2'b00, m8_q};

	assign kxy  = (mode == cik_pkg::MODE_OMNI4) ? cik_pkg::K_INV_SQRT2 : cik_pkg::K_SIN60;
	assign krot = (mode == cik_pkg::MODE_SWERVE4) ? cik_pkg::K_INV_SQRT2 : cik_pkg::K_SIN60;

	always_comb begin
		nwheel = mode[1] ? 3'd3 : 3'd4;
		if (nwheel > 3'(MAX_WHEELS)) begin
			nwheel = 3'(MAX_WHEELS);
		end
	end
	assign last_k = ({1'b0, k_q} == nwheel - 3'd1);

	assign px  = VW'(px_q) <<< 8;
	assign py  = VW'(py_q) <<< 8;
	assign rot = VW'(vrr_q) <<< 16;
	assign kx  = VW'(kxp_q >>> 8);
	assign ky  = VW'(kyp_q >>> 8);
	assign tt  = VW'(tp_q);
	assign hy  = py >>> 1;
	assign rh  = rot >>> 1;

	always_comb begin
		jx = '0;
		jy = '0;
		case (mode)
			cik_pkg::MODE_OMNI4: begin
				case (k_q)
					2'd0: jx = rot - kx - ky;
					2'd1: jx = rot + kx - ky;
					2'd2: jx = rot - kx + ky;
					default: jx = rot + kx + ky;
				endcase
			end
			cik_pkg::MODE_OMNI3: begin
				case (k_q)
					2'd0: jx = py + rot;
					2'd1: jx = -hy - kx + rot;
					default: jx = -hy + kx + rot;
				endcase
			end
			cik_pkg::MODE_SWERVE4: begin
				jx = k_q[0] ? px + tt : px - tt;
				jy = k_q[1] ? py + tt : py - tt;
			end
			default: begin
				case (k_q)
					2'd0: begin
						jx = px - rot;
						jy = py;
					end
					2'd1: begin
						jx = px + rh;
						jy = py - tt;
					end
					default: begin
						jx = px + rh;
						jy = py + tt;
					end
				endcase
			end
		endcase
	end

	assign in_ready          = state_q == F_IDLE;
	assign push              = (state_q == F_EMIT) && !full;
	assign push_data.idx     = k_q;
	assign push_data.x       = jx;
	assign push_data.y       = jy;
	assign push_data.last    = last_k;
	assign push_data.swerve  = mode[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			k_q     <= '0;
			dcnt_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_CMP;
				F_CMP: state_q <= sq_start ? F_SQRT : F_SCALE;
				F_SQRT: begin
					if (sq_done) begin
						state_q <= F_DIV;
						dcnt_q  <= '0;
					end
				end
				F_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'd33) begin
						state_q <= F_SCALE;
					end
				end
				F_SCALE: begin
					state_q <= F_EMIT;
					k_q     <= '0;
				end
				F_EMIT: begin
					if (!full) begin
						k_q <= k_q + 1'b1;
						if (last_k) begin
							state_q <= F_IDLE;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				vx_q <= vel_x;
				vy_q <= vel_y;
				vr_q <= vel_rot;
			end
			F_MUL: begin
				sqx_q  <= 31'(32'(vx_q * vx_q));
				sqy_q  <= 31'(32'(vy_q * vy_q));
				lim2_q <= 30'(limit * limit);
				ax_q   <= 30'(absx * limit);
				ay_q   <= 30'(absy * limit);
				vrr_q  <= 28'(vr_q * $signed({1'b0, radius}));
			end
			F_CMP: begin
				px_q <= 35'(vx_q) <<< 18;
				py_q <= 35'(vy_q) <<< 18;
			end
			F_SQRT: begin
				m8_q <= sq_root;
				rx_q <= 25'(ax_q[29:8]);
				ry_q <= 25'(ay_q[29:8]);
				nx_q <= {ax_q[7:0], 26'd0};
				ny_q <= {ay_q[7:0], 26'd0};
			end
			F_DIV: begin
				rx_q <= gex ? 25'(tx - {2'b00, m8_q}) : 25'(tx);
				ry_q <= gey ? 25'(ty - {2'b00, m8_q}) : 25'(ty);
				nx_q <= nx_q << 1;
				ny_q <= ny_q << 1;
				qx_q <= {qx_q[32:0], gex};
				qy_q <= {qy_q[32:0], gey};
				if (dcnt_q == 6'd33) begin
					px_q <= vx_q[15] ? -$signed({1'b0, qx_q[32:0], gex})
						: $signed({1'b0, qx_q[32:0], gex});
					py_q <= vy_q[15] ? -$signed({1'b0, qy_q[32:0], gey})
						: $signed({1'b0, qy_q[32:0], gey});
				end
			end
			F_SCALE: begin
				kxp_q <= px_q * $signed({1'b0, kxy});
				kyp_q <= py_q * $signed({1'b0, cik_pkg::K_INV_SQRT2});
				tp_q  <= vrr_q * $signed({1'b0, krot});
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/cik_back.sv =====
// Back half: turns one wheel vector into a wheel command word.
module cik_back #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cik_pkg::job_t       job,
	input  logic                empty,
	output logic                pop,
	input  logic [14:0]         limit,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          wheel_index,
	output logic signed [17:0]  wheel_speed,
	output logic signed [15:0]  steer_angle,
	output logic                last_wheel
);

	localparam int VW = cik_pkg::VW;
	localparam int CWD = VW + 2;
	localparam int NIT = (ANGLE_ITERATIONS < cik_pkg::CORDIC_MAX) ?
		ANGLE_ITERATIONS : cik_pkg::CORDIC_MAX;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_RND  = 6'b000010,
		B_MUL  = 6'b000100,
		B_SUM  = 6'b001000,
		B_WAIT = 6'b010000,
		B_DONE = 6'b100000
	} bstate_t;

	bstate_t state_q;

	cik_pkg::job_t       job_q;
	logic signed [29:0]  x8_q, y8_q;
	logic [57:0]         sx2_q, sy2_q;
	logic                sq_got_q;
	logic [28:0]         root_q;
	logic signed [17:0]  spd_q;

	logic signed [CWD-1:0] cx_q, cy_q;
	logic signed [24:0]    z_q;
	logic [4:0]            it_q;
	logic                  cbusy_q, flip_q, xzero_q, yneg_q;

	logic                  ov_q;
	logic [1:0]            oidx_q;
	logic signed [17:0]    ospd_q;
	logic signed [15:0]    oang_q;
	logic                  olast_q;

	logic                  sq_start, sq_busy, sq_done;
	logic [28:0]           sq_root;
	logic signed [VW-1:0]  r26, r18x, r18y;
	logic signed [CWD-1:0] dx, dy;
	logic signed [24:0]    at;
	logic [24:0]           zmag;
	logic [17:0]           zr;
	logic signed [17:0]    ang;
	logic [21:0]           mspd;
	logic [14:0]           spd_sw;
	logic signed [17:0]    spd_om;
	logic                  load_out;

	function automatic logic signed [VW-1:0] rnd_shift(input logic signed [VW-1:0] v,
		input int n);
		logic [VW-1:0] mag;
		logic [VW-1:0] r;
		mag = v[VW-1] ? VW'(-v) : VW'(v);
		r = (mag + (VW'(1) << (n - 1))) >> n;
		return v[VW-1] ? -$signed(r) : $signed(r);
	endfunction

	assign r26  = rnd_shift(job_q.x, 26);
	assign r18x = rnd_shift(job_q.x, 18);
	assign r18y = rnd_shift(job_q.y, 18);

	always_comb begin
		if (r26 > VW'(131071)) begin
			spd_om = 18'sd131071;
		end else if (r26 < -VW'(131072)) begin
			spd_om = -18'sd131072;
		end else begin
			spd_om = 18'(r26);
		end
	end

	assign sq_start = state_q == B_SUM;

	cik_isqrt #(.IN_W(58)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sx2_q + sy2_q),
		.busy    (sq_busy),
		.done    (sq_done),
		.root    (sq_root)
	);

	assign mspd   = 22'(({1'b0, root_q} + 30'd128) >> 8);
	assign spd_sw = (mspd > {7'd0, limit}) ? limit : 15'(mspd);

	assign dx = cy_q >>> it_q;
	assign dy = cx_q >>> it_q;
	assign at = $signed({4'd0, cik_pkg::cik_atan(it_q)});

	always_comb begin
		zmag = z_q[24] ? 25'(-z_q) : 25'(z_q);
		zr   = 18'((zmag + 25'd128) >> 8);
		ang  = z_q[24] ? -$signed(zr) : $signed(zr);
		if (flip_q) begin
			ang = ang + 18'sd18000;
		end
		if (ang > 18'sd18000) begin
			ang = ang - 18'sd36000;
		end
		if (ang <= -18'sd18000) begin
			ang = ang + 18'sd36000;
		end
		if (xzero_q) begin
			ang = yneg_q ? 18'sd18000 : 18'sd0;
		end
	end

	assign pop      = (state_q == B_IDLE) && !empty;
	assign load_out = (state_q == B_DONE) && (!ov_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			sq_got_q <= 1'b0;
			cbusy_q  <= 1'b0;
			it_q     <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (sq_done) begin
				sq_got_q <= 1'b1;
			end
			if (pop) begin
				cbusy_q <= job.swerve && (job.x != '0);
				it_q    <= '0;
			end else if (cbusy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == 5'(NIT - 1)) begin
					cbusy_q <= 1'b0;
				end
			end
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= B_RND;
					end
				end
				B_RND: state_q <= job_q.swerve ? B_MUL : B_DONE;
				B_MUL: state_q <= B_SUM;
				B_SUM: begin
					state_q  <= B_WAIT;
					sq_got_q <= 1'b0;
				end
				B_WAIT: begin
					if (sq_got_q && !cbusy_q) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q   <= job;
			xzero_q <= job.x == '0;
			yneg_q  <= job.y[VW-1];
			flip_q  <= job.y[VW-1];
			cx_q    <= job.y[VW-1] ? -CWD'(job.y) : CWD'(job.y);
			cy_q    <= job.y[VW-1] ? -CWD'(job.x) : CWD'(job.x);
			z_q     <= '0;
		end else if (cbusy_q) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + at;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - at;
			end
		end
		if (state_q == B_RND) begin
			x8_q  <= 30'(r18x);
			y8_q  <= 30'(r18y);
			spd_q <= spd_om;
		end
		if (state_q == B_MUL) begin
			sx2_q <= 58'(x8_q * x8_q);
			sy2_q <= 58'(y8_q * y8_q);
		end
		if (sq_done) begin
			root_q <= sq_root;
		end
		if (load_out) begin
			oidx_q  <= job_q.idx;
			olast_q <= job_q.last;
			ospd_q  <= job_q.swerve ? $signed({3'd0, spd_sw}) : spd_q;
			oang_q  <= job_q.swerve ? 16'(ang) : 16'sd0;
		end
	end

	assign out_valid   = ov_q;
	assign wheel_index = oidx_q;
	assign wheel_speed = ospd_q;
	assign steer_angle = oang_q;
	assign last_wheel  = olast_q;

endmodule

// ===== hdl/chassis_inverse_kinematics.sv =====
// Top level of the chassis inverse kinematics block: config registers, front, queue, back.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid/in_ready    vel_x, vel_y, vel_rot
//   out      from block out_valid/out_ready  wheel_index, wheel_speed, steer_angle, last_wheel
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// Front: a word is multiplied, compared and scaled, with a square root and two parallel
// dividers between when the planar limit engages, then one wheel per cycle is pushed
// into the queue while it is not full. Back: an omni wheel is rounded and saturated; a
// swerve wheel is paced by the 29-step square root (the angle CORDIC runs alongside it).
// Four-entry queue decouples them. Reset is asynchronous, active low; no clearing pass.
// Output register holds a word while out_ready is low and the back keeps working up to it.
module chassis_inverse_kinematics #(
	parameter int MAX_WHEELS       = 4,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  vel_x,
	input  logic signed [15:0]  vel_y,
	input  logic signed [15:0]  vel_rot,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          wheel_index,
	output logic signed [17:0]  wheel_speed,
	output logic signed [15:0]  steer_angle,
	output logic                last_wheel,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [14:0]         cfg_data
);

	logic [1:0]    mode_q;
	logic [10:0]   radius_q;
	logic [14:0]   limit_q;

	logic          push, full, pop, empty;
	cik_pkg::job_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cik_pkg::MODE_OMNI4;
			radius_q <= 11'd300;
			limit_q  <= 15'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				cik_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				cik_pkg::REG_RADIUS: radius_q <= cfg_data[10:0];
				cik_pkg::REG_LIMIT:  limit_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cik_front #(.MAX_WHEELS(MAX_WHEELS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_rot   (vel_rot),
		.mode      (mode_q),
		.radius    (radius_q),
		.limit     (limit_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	cik_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	cik_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (pop_data),
		.empty       (empty),
		.pop         (pop),
		.limit       (limit_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.wheel_index (wheel_index),
		.wheel_speed (wheel_speed),
		.steer_angle (steer_angle),
		.last_wheel  (last_wheel)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for chassis inverse kinematics: directed, random velocity words, scored per wheel.
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vr;
	} vel_cmd_t;

	typedef struct packed {
		logic [1:0]         idx;
		logic signed [17:0] spd;
		logic signed [15:0] ang;
		logic               last;
	} wheel_cmd_t;

	localparam int LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] vel_x = '0, vel_y = '0, vel_rot = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] wheel_index;
	logic signed [17:0] wheel_speed;
	logic signed [15:0] steer_angle;
	logic last_wheel;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [14:0] cfg_data = '0;

	chassis_inverse_kinematics DUT (.*);

	always #10 clk = ~clk;

	vel_cmd_t pending_cmds[$];
	wheel_cmd_t expected_wheels[$];
	logic [1:0] mode_r = cik_pkg::MODE_OMNI4;
	longint radius_r = 300, limit_r = 3000;
	int send_idle = 9, recv_idle = 57;
	int mismatches = 0, wheels_seen = 0, words_sent = 0, stall_cnt = 0;

	function automatic longint floor_sh(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint round_sh(longint v, int n);
		longint h;
		h = longint'(1) << (n - 1);
		if (v >= 0) return (v + h) >>> n;
		return -((-v + h) >>> n);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint atan_step(int i);
		longint t[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
			5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};
		return t[i];
	endfunction

	function automatic longint steer_deg(longint x, longint y);
		longint cx, cy, z, a, dx, dy;
		bit flip;
		if (x == 0) return (y >= 0) ? 0 : 18000;
		cx = y; cy = x; z = 0; flip = 0;
		if (cx < 0) begin
			cx = -cx; cy = -cy; flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_sh(cy, i);
			dy = floor_sh(cx, i);
			if (cy > 0) begin
				cx += dx; cy -= dy; z += atan_step(i);
			end else begin
				cx -= dx; cy += dy; z -= atan_step(i);
			end
		end
		a = round_sh(z, 8);
		if (flip) a += 18000;
		if (a > 18000) a -= 36000;
		if (a <= -18000) a += 36000;
		return a;
	endfunction

	task automatic predict_wheels(vel_cmd_t c);
		longint vx, vy, vr, s, m8, px, py, rot, kx, ky, t, rs, rh, x8, y8, m;
		longint sx[4], sy[4];
		int n;
		bit sw;
		wheel_cmd_t w;
		vx = c.vx; vy = c.vy; vr = c.vr;
		s = vx * vx + vy * vy;
		sw = mode_r[0];
		if (s > limit_r * limit_r) begin
			m8 = int_sqrt(longint'(s) << 16);
			px = (vx * limit_r * 67108864 / m8) * 256;
			py = (vy * limit_r * 67108864 / m8) * 256;
		end else begin
			px = vx * 67108864;
			py = vy * 67108864;
		end
		rot = vr * radius_r * 65536;
		sy = '{0, 0, 0, 0};
		case (mode_r)
			cik_pkg::MODE_OMNI4: begin
				kx = floor_sh(px * 46341, 16);
				ky = floor_sh(py * 46341, 16);
				sx = '{rot - kx - ky, rot + kx - ky, rot - kx + ky, rot + kx + ky};
				n = 4;
			end
			cik_pkg::MODE_OMNI3: begin
				kx = floor_sh(px * 56756, 16);
				ky = floor_sh(py, 1);
				sx = '{py + rot, -ky - kx + rot, -ky + kx + rot, 0};
				n = 3;
			end
			cik_pkg::MODE_SWERVE4: begin
				t = floor_sh(rot * 46341, 16);
				sx = '{px - t, px + t, px - t, px + t};
				sy = '{py - t, py - t, py + t, py + t};
				n = 4;
			end
			default: begin
				rs = floor_sh(rot * 56756, 16);
				rh = floor_sh(rot, 1);
				sx = '{px - rot, px + rh, px + rh, 0};
				sy = '{py, py - rs, py + rs, 0};
				n = 3;
			end
		endcase
		for (int k = 0; k < n; k++) begin
			w.idx = 2'(k);
			w.last = (k == n - 1);
			if (sw) begin
				x8 = round_sh(sx[k], 18);
				y8 = round_sh(sy[k], 18);
				m = round_sh(int_sqrt(x8 * x8 + y8 * y8), 8);
				if (m > limit_r) m = limit_r;
				w.spd = 18'(m);
				w.ang = 16'(steer_deg(sx[k], sy[k]));
			end else begin
				m = round_sh(sx[k], 26);
				if (m > 131071) m = 131071;
				if (m < -131072) m = -131072;
				w.spd = 18'(m);
				w.ang = '0;
			end
			expected_wheels.push_back(w);
		end
	endtask

	// driver
	always @(posedge clk) begin
		vel_cmd_t c;
		if (in_valid && in_ready) begin
			predict_wheels(pending_cmds.pop_front());
			words_sent++;
		end
		if (!(in_valid && !in_ready)) begin
			if (pending_cmds.size() > 0 && !(in_valid && in_ready && pending_cmds.size() == 0)
				&& $urandom_range(99) >= send_idle) begin
				c = pending_cmds[0];
				in_valid <= 1'b1;
				vel_x <= c.vx; vel_y <= c.vy; vel_rot <= c.vr;
			end else
				in_valid <= 1'b0;
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// monitor
	always @(posedge clk) begin
		wheel_cmd_t e;
		if (out_valid && out_ready) begin
			wheels_seen++;
			if (expected_wheels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: idx %0d speed %0d angle %0d last %0b",
						wheel_index, wheel_speed, steer_angle, last_wheel);
			end else begin
				e = expected_wheels.pop_front();
				if (e.idx !== wheel_index || e.spd !== wheel_speed ||
					e.ang !== steer_angle || e.last !== last_wheel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("wheel mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
							e.idx, e.spd, e.ang, e.last,
							wheel_index, wheel_speed, steer_angle, last_wheel);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= LIMIT) begin
			$display("watchdog expired");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_vel();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(8000) - 4000);
			3: return 16'($urandom_range(200) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_wheels.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int d);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= 15'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cik_pkg::REG_MODE: mode_r = 2'(d);
			cik_pkg::REG_RADIUS: radius_r = longint'(d[10:0]);
			default: limit_r = longint'(d[14:0]);
		endcase
	endtask

	task automatic push_cmd(int x, int y, int r);
		vel_cmd_t c;
		c.vx = 16'(x); c.vy = 16'(y); c.vr = 16'(r);
		pending_cmds.push_back(c);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, zero vector, axis cases in each mode
		for (int m = 0; m < 4; m++) begin
			write_reg(cik_pkg::REG_MODE, m);
			push_cmd(0, 0, 0);
			push_cmd(0, -500, 0);
			push_cmd(16'sh7fff, 16'sh8000, 16'sh7fff);
			push_cmd(16'sh8000, 16'sh7fff, 16'sh8000);
			push_cmd(1000, 1000, -1024);
			push_cmd(-1, 16'shffff, 16'sh5555);
			drain();
		end
		write_reg(cik_pkg::REG_LIMIT, 0);
		write_reg(cik_pkg::REG_RADIUS, 2047);
		push_cmd(100, -100, 16'sh2aaa);
		drain();
		write_reg(cik_pkg::REG_MODE, cik_pkg::MODE_SWERVE4);
		push_cmd(16'sh8000, 3, 16'sh7fff);
		drain();
		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin send_idle = 57; recv_idle = 9; end
			if (ph == 6) begin send_idle = 0; recv_idle = 0; end
			write_reg(cik_pkg::REG_MODE, $urandom_range(3));
			write_reg(cik_pkg::REG_RADIUS,
				(ph == 1) ? 0 : (ph == 2) ? 2047 : $urandom_range(2047));
			write_reg(cik_pkg::REG_LIMIT,
				(ph == 4) ? 32767 : (ph == 5) ? 0 : $urandom_range(32767));
			for (int i = 0; i < 40; i++) push_cmd(rand_vel(), rand_vel(), rand_vel());
			drain();
		end
		$display("sent %0d velocity words, checked %0d wheel words over all four modes",
			words_sent, wheels_seen);
		$display("radius and speed limit swept through zero and full scale");
		if (mismatches == 0 && expected_wheels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
